[src/lbsd_pkg.sv]
// ----------------------------------------------------------------------------
// lbsd_pkg
// Shared types and constants of the block-stream LZSS decoder.
// ----------------------------------------------------------------------------
package lbsd_pkg;

   // history window and position widths
   localparam int WIN_ADDR_W = 11;
   localparam int POS_W      = WIN_ADDR_W + 1;
   localparam int LEN_W      = 6;
   localparam int BLK_LEN_W  = 15;

   // position counts up to twice the window, then steps back by one window
   localparam logic [POS_W-1:0] POS_LAST   = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] POS_REWIND = {1'b1, {WIN_ADDR_W{1'b0}}};

   // match length is stored minus this bias
   localparam logic [LEN_W-1:0] MATCH_BIAS = 6'd3;

   // stream parse phase
   typedef enum logic [2:0] {
      PH_SIZE   = 3'd0,
      PH_BHDR   = 3'd1,
      PH_STORED = 3'd2,
      PH_ITEM   = 3'd3,
      PH_DATA   = 3'd4,
      PH_LOW    = 3'd5,
      PH_SKIP   = 3'd6,
      PH_DONE   = 3'd7
   } phase_type;

   // sequencer state
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_MRD  = 2'd2,
      ST_MWR  = 2'd3
   } ctl_state_type;

   // history write port
   typedef struct packed {
      logic                  en;
      logic [WIN_ADDR_W-1:0] addr;
      logic [7:0]            data;
   } hist_wr_type;

   // copy source from the shared address unit
   typedef struct packed {
      logic                  before_start;
      logic [WIN_ADDR_W-1:0] addr;
   } src_type;

endpackage

[src/lzss_block_stream_decoder.sv]
// ----------------------------------------------------------------------------
// lzss_block_stream_decoder
// Byte-serial LZSS block-stream decoder with a 2048-byte history window.
// ----------------------------------------------------------------------------
// A stream byte is registered when taken and worked on once the result
// register is free; the next is taken only when the sequencer is idle.
// A match copies its bytes one at a time, one history read and one write
// per byte through the single history port pair and the shared subtractor.
// Reset: synchronous, active high; parser goes back to the size header,
// history contents are left as they are.
module lzss_block_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // run_last
   output logic       rsp_tuser    // [0] stream_done
);
   import lbsd_pkg::*;

   ctl_state_type          state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [1:0]             hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]            total_ff, total_in;
   logic [31:0]            produced_ff, produced_in;
   logic [BLK_LEN_W-1:0]   rem_ff, rem_in;
   logic [8:0]             flag_ff, flag_in;
   logic [7:0]             high_ff, high_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [7:0]             first_ff, first_in;
   logic [7:0]             in_byte_ff, in_byte_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [POS_W-1:0]       dist_ff, dist_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_done_ff, rsp_done_in;

   logic                   out_free;
   logic [31:0]            produced_inc;
   logic                   done_hit;
   logic [BLK_LEN_W-1:0]   rem_dec;
   logic [8:0]             flag_shr;
   logic                   flag_reload;
   logic [POS_W-1:0]       pos_next;
   logic [15:0]            word;
   logic [15:0]            blk_hdr;
   logic                   take_bit;
   logic [7:0]             copy_byte;
   logic                   emit;
   logic                   emit_last;
   logic [7:0]             emit_byte;
   hist_wr_type            hist_wr;
   logic                   hist_rd_en;
   logic [7:0]             hist_rd_data;
   src_type                src;

   // history window and shared source address unit
   lbsd_history u_history (
      .clock   (clock),
      .wr      (hist_wr),
      .rd_en   (hist_rd_en),
      .rd_addr (src.addr),
      .rd_data (hist_rd_data)
   );

   lbsd_addr_unit u_addr_unit (
      .pos       (pos_ff),
      .back_dist (dist_ff),
      .src       (src)
   );

   // shared helpers
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign produced_inc = produced_ff + 32'd1;
   assign done_hit     = (produced_inc == total_ff);
   assign rem_dec      = rem_ff - {{(BLK_LEN_W-1){1'b0}}, 1'b1};
   assign flag_shr     = {1'b0, flag_ff[8:1]};
   // sentinel bit has reached bit 1 or below: all eight flags used
   assign flag_reload  = (flag_ff[8:2] == 7'd0);
   assign pos_next     = (pos_ff == POS_LAST) ? POS_REWIND
                                              : pos_ff + {{(POS_W-1){1'b0}}, 1'b1};
   assign word         = {high_ff, in_byte_ff};
   assign blk_hdr      = {high_ff, in_byte_ff};
   assign take_bit     = (phase_ff == PH_ITEM) ? flag_shr[0] : flag_ff[0];
   assign copy_byte    = src.before_start ? first_ff : hist_rd_data;
   assign hist_rd_en   = (state_ff == ST_MRD);
   assign req_tready   = (state_ff == ST_IDLE);

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = (phase_ff == PH_LOW) ? ST_MRD : ST_IDLE;
            end
         end
         ST_MRD: begin
            state_in = ST_MWR;
         end
         ST_MWR: begin
            if (out_free) begin
               if (done_hit || len_ff == {{(LEN_W-1){1'b0}}, 1'b1}) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MRD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // parser and copy datapath
   always_comb begin
      phase_in     = phase_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      total_in     = total_ff;
      produced_in  = produced_ff;
      rem_in       = rem_ff;
      flag_in      = flag_ff;
      high_in      = high_ff;
      pos_in       = pos_ff;
      first_in     = first_ff;
      in_byte_in   = in_byte_ff;
      len_in       = len_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      emit         = 1'b0;
      emit_last    = 1'b1;
      emit_byte    = in_byte_ff;
      hist_wr.en   = 1'b0;
      hist_wr.addr = pos_ff[WIN_ADDR_W-1:0];
      hist_wr.data = in_byte_ff;

      // take a stream byte
      if (state_ff == ST_IDLE && req_tvalid) begin
         in_byte_in = req_tdata;
      end

      // one parse step per stream byte
      if (state_ff == ST_EXEC && out_free) begin
         case (phase_ff)
            PH_SIZE: begin
               total_in   = {total_ff[23:0], in_byte_ff};
               hdr_cnt_in = hdr_cnt_ff + 2'd1;
               if (hdr_cnt_ff == 2'd3) begin
                  produced_in = 32'd0;
                  phase_in    = (total_in == 32'd0) ? PH_DONE : PH_BHDR;
               end
            end
            PH_BHDR: begin
               if (hdr_cnt_ff == 2'd0) begin
                  high_in    = in_byte_ff;
                  hdr_cnt_in = 2'd1;
               end else begin
                  hdr_cnt_in = 2'd0;
                  rem_in     = blk_hdr[BLK_LEN_W-1:0];
                  if (blk_hdr[15]) begin
                     phase_in = (rem_in != '0) ? PH_STORED : PH_BHDR;
                  end else begin
                     flag_in  = 9'd0;
                     pos_in   = '0;
                     first_in = 8'd0;
                     if (rem_in == '0) begin
                        phase_in = PH_BHDR;
                     end else if (rem_in == {{(BLK_LEN_W-1){1'b0}}, 1'b1}) begin
                        phase_in = PH_SKIP;
                     end else begin
                        phase_in = PH_ITEM;
                     end
                  end
               end
            end
            PH_STORED: begin
               rem_in = rem_dec;
               emit   = 1'b1;
               if (done_hit) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = (rem_dec != '0) ? PH_STORED : PH_BHDR;
               end
            end
            PH_SKIP: begin
               rem_in   = '0;
               phase_in = PH_BHDR;
            end
            PH_ITEM, PH_DATA: begin
               rem_in = rem_dec;
               if (phase_ff == PH_ITEM && flag_reload) begin
                  // new flag byte, sentinel above the eight flags
                  flag_in  = {1'b1, in_byte_ff};
                  phase_in = (rem_dec != '0) ? PH_DATA : PH_BHDR;
               end else begin
                  if (phase_ff == PH_ITEM) begin
                     flag_in = flag_shr;
                  end
                  if (take_bit) begin
                     // high byte of a match word
                     high_in  = in_byte_ff;
                     phase_in = (rem_dec != '0) ? PH_LOW : PH_BHDR;
                  end else begin
                     // literal
                     emit       = 1'b1;
                     hist_wr.en = 1'b1;
                     if (pos_ff == '0) begin
                        first_in = in_byte_ff;
                     end
                     pos_in = pos_next;
                     if (done_hit) begin
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = (rem_dec != '0) ? PH_ITEM : PH_BHDR;
                     end
                  end
               end
            end
            PH_LOW: begin
               // low byte of a match word: set up the copy
               rem_in  = rem_dec;
               len_in  = {1'b0, word[4:0]} + MATCH_BIAS;
               dist_in = {1'b0, word[15:5]} + {{(POS_W-1){1'b0}}, 1'b1};
            end
            default: begin
            end
         endcase
      end

      // copy one match byte
      if (state_ff == ST_MWR && out_free) begin
         emit         = 1'b1;
         emit_byte    = copy_byte;
         emit_last    = done_hit || (len_ff == {{(LEN_W-1){1'b0}}, 1'b1});
         hist_wr.en   = 1'b1;
         hist_wr.data = copy_byte;
         if (pos_ff == '0) begin
            first_in = copy_byte;
         end
         pos_in = pos_next;
         len_in = len_ff - {{(LEN_W-1){1'b0}}, 1'b1};
         if (done_hit) begin
            phase_in = PH_DONE;
         end else if (len_ff == {{(LEN_W-1){1'b0}}, 1'b1}) begin
            phase_in = (rem_ff != '0) ? PH_ITEM : PH_BHDR;
         end
      end

      // result register load
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
         rsp_done_in  = done_hit;
         produced_in  = produced_inc;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SIZE;
         hdr_cnt_ff   <= 2'd0;
         total_ff     <= 32'd0;
         produced_ff  <= 32'd0;
         rem_ff       <= '0;
         flag_ff      <= 9'd0;
         high_ff      <= 8'd0;
         pos_ff       <= '0;
         first_ff     <= 8'd0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         total_ff     <= total_in;
         produced_ff  <= produced_in;
         rem_ff       <= rem_in;
         flag_ff      <= flag_in;
         high_ff      <= high_in;
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      dist_ff     <= dist_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

endmodule

[src/lbsd_history.sv]
// ----------------------------------------------------------------------------
// lbsd_history
// 2048-byte history window, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lbsd_history (
   input  logic                                clock,
   input  lbsd_pkg::hist_wr_type               wr,
   input  logic                                rd_en,
   input  logic [lbsd_pkg::WIN_ADDR_W-1:0]     rd_addr,
   output logic [7:0]                          rd_data
);
   import lbsd_pkg::*;

   localparam int DEPTH = 1 << WIN_ADDR_W;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read port, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/lbsd_addr_unit.sv]
// ----------------------------------------------------------------------------
// lbsd_addr_unit
// Shared subtractor: copy source position and before-block-start test.
// ----------------------------------------------------------------------------
module lbsd_addr_unit (
   input  logic [lbsd_pkg::POS_W-1:0] pos,
   input  logic [lbsd_pkg::POS_W-1:0] back_dist,
   output lbsd_pkg::src_type          src
);
   import lbsd_pkg::*;

   logic [POS_W:0] diff;

   // borrow out of pos - back_dist marks a source before the block start
   assign diff             = {1'b0, pos} - {1'b0, back_dist};
   assign src.before_start = diff[POS_W];
   assign src.addr         = diff[WIN_ADDR_W-1:0];

endmodule

[sim/tb_lzss_block_stream_decoder.sv]
// ----------------------------------------------------------------------------
// tb_lzss_block_stream_decoder
// Feeds one long compressed stream into the decoder and checks every decoded
// byte against an in-bench block-stream LZSS model or a pinned table result.
// The stream opens with a short table of hand-picked requests (size header,
// stored, empty, length-one and cut blocks, extreme matches). Random stored
// and compressed blocks follow. A final long compressed block rewinds the
// position counter and hits the declared total in the middle of a match.
// ----------------------------------------------------------------------------
module tb_lzss_block_stream_decoder;
   import lbsd_pkg::*;

   // run limits
   localparam int CYCLE_LIMIT    = 400000;
   localparam int RANDOM_REQS    = 60;
   localparam int RANDOM_OUT_CAP = 220;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 80;
   localparam int WIN            = 2048;

   // one decoded byte as seen on the result channel
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       done;
   } dec_byte_type;

   // directed request table; pinned rows carry their result inline
   typedef struct packed {
      logic [7:0] data;
      logic       pinned;
      logic       has_out;
      logic [7:0] out;
   } stim_row_type;

   typedef enum logic [1:0] {
      IDLE_NONE = 2'd0,
      IDLE_SEND = 2'd1,
      IDLE_RECV = 2'd2,
      IDLE_BOTH = 2'd3
   } idle_mode_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] in_byte
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] out_byte
   logic       rsp_tlast;   // run_last
   logic       rsp_tuser;   // [0] stream_done

   lzss_block_stream_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   // decoder model state
   phase_type   parse_ph;
   logic [1:0]  hdr_cnt;
   logic [31:0] total_len;
   logic [31:0] out_count;
   logic [14:0] blk_left;
   logic        blk_stored;
   logic [15:0] flag_bits;
   logic [7:0]  hi_byte;
   logic [15:0] blk_pos;
   logic [7:0]  blk_first;
   logic [7:0]  window [0:WIN-1];

   dec_byte_type step_out[$];
   dec_byte_type expected_bytes[$];
   logic [7:0]   blk_q[$];

   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           req_count = 0;
   int           checked = 0;
   int           errors = 0;
   int           cyc = 0;
   dec_byte_type want;

   // directed part: size header of 0x1400, stored, empty, length-one,
   // then a compressed block with a max match before block start and a cut
   stim_row_type directed_rows [0:23] = '{
      '{8'h00, 1'b1, 1'b0, 8'h00},
      '{8'h00, 1'b1, 1'b0, 8'h00},
      '{8'h14, 1'b1, 1'b0, 8'h00},
      '{8'h00, 1'b1, 1'b0, 8'h00},
      '{8'h80, 1'b1, 1'b0, 8'h00},
      '{8'h02, 1'b1, 1'b0, 8'h00},
      '{8'h00, 1'b1, 1'b1, 8'h00},
      '{8'hff, 1'b1, 1'b1, 8'hff},
      '{8'h80, 1'b1, 1'b0, 8'h00},
      '{8'h00, 1'b1, 1'b0, 8'h00},
      '{8'h00, 1'b1, 1'b0, 8'h00},
      '{8'h00, 1'b1, 1'b0, 8'h00},
      '{8'h00, 1'b1, 1'b0, 8'h00},
      '{8'h01, 1'b1, 1'b0, 8'h00},
      '{8'ha5, 1'b1, 1'b0, 8'h00},
      '{8'h00, 1'b1, 1'b0, 8'h00},
      '{8'h07, 1'b1, 1'b0, 8'h00},
      '{8'h0d, 1'b1, 1'b0, 8'h00},
      '{8'hff, 1'b1, 1'b0, 8'h00},
      '{8'hff, 1'b0, 1'b0, 8'h00},
      '{8'h5a, 1'b1, 1'b1, 8'h5a},
      '{8'h00, 1'b1, 1'b0, 8'h00},
      '{8'h00, 1'b0, 1'b0, 8'h00},
      '{8'h12, 1'b1, 1'b0, 8'h00}
   };

   // ------------------------------------------------------------------
   // decoder model
   // ------------------------------------------------------------------
   function automatic void set_phase(input phase_type p);
      if (parse_ph != PH_DONE)
         parse_ph = p;
   endfunction

   function automatic void emit_byte(input logic [7:0] b);
      dec_byte_type d;
      if (parse_ph == PH_DONE)
         return;
      out_count = out_count + 1;
      d.data = b;
      d.last = 1'b0;
      d.done = (out_count == total_len);
      if (d.done)
         parse_ph = PH_DONE;
      step_out.push_back(d);
   endfunction

   // write to history, advance position with rewind, then output
   function automatic void put_decoded(input logic [7:0] b);
      int nxt;
      window[blk_pos[10:0]] = b;
      if (blk_pos == 16'd0)
         blk_first = b;
      nxt = int'(blk_pos) + 1;
      if (nxt >= 2 * WIN)
         nxt = nxt - WIN;
      blk_pos = 16'(nxt);
      emit_byte(b);
   endfunction

   function automatic void take_data(input logic [7:0] b);
      if (flag_bits[0]) begin
         hi_byte = b;
         set_phase((blk_left != 0) ? PH_LOW : PH_BHDR);
      end else begin
         put_decoded(b);
         set_phase((blk_left != 0) ? PH_ITEM : PH_BHDR);
      end
   endfunction

   function automatic void lzss_decode_step(input logic [7:0] b);
      logic [15:0] w;
      logic [15:0] f;
      int          len;
      int          back_dist;
      int          k;
      logic [7:0]  v;
      step_out.delete();
      case (parse_ph)
         PH_SIZE: begin
            total_len = {total_len[23:0], b};
            hdr_cnt = hdr_cnt + 2'd1;
            if (hdr_cnt == 2'd0) begin
               out_count = 32'd0;
               parse_ph = (total_len == 32'd0) ? PH_DONE : PH_BHDR;
            end
         end
         PH_BHDR: begin
            if (hdr_cnt == 2'd0) begin
               hi_byte = b;
               hdr_cnt = 2'd1;
            end else begin
               w = {hi_byte, b};
               hdr_cnt = 2'd0;
               blk_left = w[14:0];
               if (w[15]) begin
                  blk_stored = 1'b1;
                  parse_ph = (blk_left != 0) ? PH_STORED : PH_BHDR;
               end else begin
                  blk_stored = 1'b0;
                  flag_bits = 16'd0;
                  blk_pos = 16'd0;
                  blk_first = 8'd0;
                  if (blk_left == 0)
                     parse_ph = PH_BHDR;
                  else if (blk_left == 1)
                     parse_ph = PH_SKIP;
                  else
                     parse_ph = PH_ITEM;
               end
            end
         end
         PH_STORED: begin
            blk_left = blk_left - 15'd1;
            emit_byte(b);
            set_phase((blk_left != 0) ? PH_STORED : PH_BHDR);
         end
         PH_SKIP: begin
            blk_left = 15'd0;
            parse_ph = PH_BHDR;
         end
         PH_ITEM: begin
            f = flag_bits >> 1;
            blk_left = blk_left - 15'd1;
            if (!f[8]) begin
               flag_bits = {8'hff, b};
               parse_ph = (blk_left != 0) ? PH_DATA : PH_BHDR;
            end else begin
               flag_bits = f;
               take_data(b);
            end
         end
         PH_DATA: begin
            blk_left = blk_left - 15'd1;
            take_data(b);
         end
         PH_LOW: begin
            w = {hi_byte, b};
            len = int'(w[4:0]) + 3;
            back_dist = int'(w[15:5]) + 1;
            blk_left = blk_left - 15'd1;
            for (k = 0; k < len && parse_ph != PH_DONE; k++) begin
               if (int'(blk_pos) < back_dist)
                  v = blk_first;
               else
                  v = window[(int'(blk_pos) - back_dist) & (WIN - 1)];
               put_decoded(v);
            end
            set_phase((blk_left != 0) ? PH_ITEM : PH_BHDR);
         end
         default: ;
      endcase
      if (step_out.size() > 0)
         step_out[step_out.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic void set_idling(input idle_mode_type m);
      send_idle_pct  = (m == IDLE_SEND) ? 73 : (m == IDLE_BOTH) ? 28 : 0;
      recv_stall_pct = (m == IDLE_RECV) ? 73 : (m == IDLE_BOTH) ? 28 : 0;
   endfunction

   // well-formed compressed payload of exactly len bytes, last item may be cut
   function automatic void build_compressed(input int len);
      logic [7:0]  flag;
      logic [10:0] dm1;
      logic [4:0]  lc;
      int          k;
      blk_q.delete();
      while (blk_q.size() < len) begin
         flag = 8'($urandom);
         blk_q.push_back(flag);
         for (k = 0; k < 8 && blk_q.size() < len; k++) begin
            if (flag[k]) begin
               case ($urandom_range(0, 3))
                  0, 1:    dm1 = 11'($urandom_range(0, 15));
                  2:       dm1 = 11'($urandom_range(0, 255));
                  default: dm1 = 11'($urandom);
               endcase
               lc = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
               blk_q.push_back(dm1[10:3]);
               blk_q.push_back({dm1[2:0], lc});
            end else begin
               blk_q.push_back(8'($urandom));
            end
         end
      end
      while (blk_q.size() > len)
         void'(blk_q.pop_back());
   endfunction

   // one request; for pinned table rows the inline result replaces the model's
   task automatic send_byte(input logic [7:0] b, input logic pinned = 1'b0,
                            input logic has_out = 1'b0, input logic [7:0] out = 8'h00);
      dec_byte_type d;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do
         @(posedge clock);
      while (!req_tready);
      req_count++;
      lzss_decode_step(b);
      if (pinned) begin
         if (has_out) begin
            d.data = out;
            d.last = 1'b1;
            d.done = 1'b0;
            expected_bytes.push_back(d);
         end
      end else begin
         foreach (step_out[i])
            expected_bytes.push_back(step_out[i]);
      end
   endtask

   task automatic send_header(input logic stored, input int len);
      send_byte({stored, 7'(len >> 8)});
      send_byte(8'(len));
   endtask

   task automatic send_match(input logic [10:0] dm1, input logic [4:0] lc);
      send_byte(dm1[10:3]);
      send_byte({dm1[2:0], lc});
   endtask

   // hold the sender until every expected byte has come out
   task automatic drain_results(input int settle);
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // receiver side
   // ------------------------------------------------------------------
   always @(posedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

   task automatic report(input string what, input int got, input int exp_val);
      $display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
               cyc, what, got, exp_val);
      errors++;
   endtask

   // compare each decoded byte with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            report("unexpected decoded byte", rsp_tdata, 0);
         end else begin
            want = expected_bytes.pop_front();
            checked++;
            if (rsp_tdata !== want.data)
               report("out_byte", rsp_tdata, want.data);
            if (rsp_tlast !== want.last)
               report("run_last", rsp_tlast, want.last);
            if (rsp_tuser !== want.done)
               report("stream_done", rsp_tuser, want.done);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still expected",
                  cyc, expected_bytes.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int          k;
      int          len;
      int          kind;
      int          blk_idx;
      int          grp;
      int          rand_start;
      int          remaining;
      logic        lead_literal;
      logic [10:0] dm1;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      rsp_tready = 1'b0;

      // model reset
      parse_ph   = PH_SIZE;
      hdr_cnt    = 2'd0;
      total_len  = 32'd0;
      out_count  = 32'd0;
      blk_left   = 15'd0;
      blk_stored = 1'b0;
      flag_bits  = 16'd0;
      hi_byte    = 8'd0;
      blk_pos    = 16'd0;
      blk_first  = 8'd0;
      for (k = 0; k < WIN; k++)
         window[k] = 8'd0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling
      set_idling(IDLE_NONE);
      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].pinned,
                   directed_rows[i].has_out, directed_rows[i].out);
      drain_results(SETTLE_CYCLES);

      // random stored and compressed blocks
      rand_start = req_count;
      blk_idx = 0;
      while (req_count - rand_start < RANDOM_REQS && out_count <= RANDOM_OUT_CAP) begin
         set_idling(idle_mode_type'((blk_idx / 5) % 4));
         if (blk_idx % 17 == 16)
            drain_results(SETTLE_CYCLES);
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 16);
            send_header(1'b1, len);
            for (k = 0; k < len; k++)
               send_byte(8'($urandom));
         end else if (kind < 35) begin
            // noise: arbitrary payload bytes
            len = $urandom_range(0, 24);
            send_header(1'b0, len);
            for (k = 0; k < len; k++)
               send_byte(8'($urandom));
         end else begin
            case ($urandom_range(0, 19))
               0:       len = 0;
               1:       len = 1;
               default: len = $urandom_range(2, 48);
            endcase
            build_compressed(len);
            send_header(1'b0, len);
            foreach (blk_q[i])
               send_byte(blk_q[i]);
         end
         blk_idx++;
      end

      // long block: position rewinds, total is reached inside a match
      send_header(1'b0, 32767);
      remaining = int'(total_len - out_count);
      lead_literal = (remaining % 34 == 0);
      grp = 0;
      while (parse_ph != PH_DONE) begin
         set_idling(idle_mode_type'((grp / 5) % 4));
         send_byte(lead_literal ? 8'hfe : 8'hff);
         for (k = 0; k < 8 && parse_ph != PH_DONE; k++) begin
            if (lead_literal && k == 0) begin
               send_byte(8'($urandom));
            end else begin
               dm1 = 11'($urandom);
               send_match(dm1, 5'h1f);
            end
         end
         lead_literal = 1'b0;
         grp++;
      end

      // bytes after the end of the stream are ignored
      for (k = 0; k < 4; k++)
         send_byte(8'($urandom));

      drain_results(END_CYCLES);

      $display("stream of %0d request bytes over %0d random blocks, total size %0d",
               req_count, blk_idx, total_len);
      $display("%0d decoded bytes compared, %0d mismatches", checked, errors);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

[sim.f]
src/lbsd_pkg.sv
src/lbsd_history.sv
src/lbsd_addr_unit.sv
src/lzss_block_stream_decoder.sv
sim/tb_lzss_block_stream_decoder.sv
